### design/sorted_multiset_count_lookup_top_assert.svh
// Assertion macros for the sorted multiset count lookup checker.
// No dependencies; included by the checker file only.
`ifndef SORTED_MULTISET_COUNT_LOOKUP_TOP_ASSERT_SVH
`define SORTED_MULTISET_COUNT_LOOKUP_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SMCL_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SMCL_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/smcl_pkg.sv
// Shared constants, payload structs and cell control struct for the
// sorted multiset count lookup. No dependencies.
`default_nettype none

package smcl_pkg;

  localparam int CAPACITY    = 1024;
  localparam int COUNT_BITS  = 20;
  localparam int KEY_W       = 32;
  localparam int OUT_COUNT_W = 20;
  localparam int USED_W      = $clog2(CAPACITY + 1);
  localparam int GROUP_SIZE  = 32;
  localparam int NUM_GROUPS  = (CAPACITY + GROUP_SIZE - 1) / GROUP_SIZE;
  localparam int PAD_CELLS   = NUM_GROUPS * GROUP_SIZE;

  // Flipping the sign bit makes unsigned order match signed order.
  localparam logic [KEY_W-1:0] SIGN_FLIP = {1'b1, {(KEY_W-1){1'b0}}};

  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_QUERY  = 1'b1;

  typedef logic [KEY_W-1:0]      key_t;
  typedef logic [COUNT_BITS-1:0] tally_t;

  typedef struct packed {
    logic              func;
    logic signed [31:0] value;
  } in_t;

  typedef struct packed {
    logic [OUT_COUNT_W-1:0] count;
    logic                   dropped;
  } out_t;

  // Broadcast from the sequencer to every cell.
  typedef struct packed {
    logic cmp_en;
    logic shift_en;
    logic inc_en;
    logic query;
    key_t key;
  } ctrl_t;

endpackage

`default_nettype wire

### design/smcl_cell.sv
// One table cell: holds a key and its tally, compares against the broadcast
// key and shifts from its lower neighbor on insertion. Uses smcl_pkg.
`default_nettype none

module smcl_cell (
  input  wire               clk,
  input  smcl_pkg::ctrl_t   ctrl,
  input  wire               valid,
  input  smcl_pkg::key_t    prev_key,
  input  smcl_pkg::tally_t  prev_tally,
  input  wire               prev_lt,
  output smcl_pkg::key_t    key,
  output smcl_pkg::tally_t  tally,
  output logic              lt,
  output logic              eq,
  output smcl_pkg::tally_t  contrib
);
  import smcl_pkg::*;

  key_t   key_r;
  tally_t tally_r;
  logic   lt_r;
  logic   eq_r;
  tally_t contrib_r;
  tally_t tally_sat;
  logic   eq_now;

  // Saturating increment of the stored tally.
  assign tally_sat = (tally_r == {COUNT_BITS{1'b1}}) ? tally_r : tally_r + tally_t'(1);
  assign eq_now    = valid && (key_r == ctrl.key);

  // Compare phase: record order flags and this cell's share of the answer.
  always_ff @(posedge clk) begin
    if (ctrl.cmp_en) begin
      lt_r      <= valid && (key_r < ctrl.key);
      eq_r      <= eq_now;
      contrib_r <= eq_now ? (ctrl.query ? tally_r : tally_sat) : '0;
    end
  end

  // Commit phase: open a slot at the sorted position or bump the match.
  always_ff @(posedge clk) begin
    if (ctrl.shift_en && !lt_r) begin
      if (prev_lt) begin
        key_r   <= ctrl.key;
        tally_r <= tally_t'(1);
      end else begin
        key_r   <= prev_key;
        tally_r <= prev_tally;
      end
    end else if (ctrl.inc_en && eq_r) begin
      tally_r <= tally_sat;
    end
  end

  assign key     = key_r;
  assign tally   = tally_r;
  assign lt      = lt_r;
  assign eq      = eq_r;
  assign contrib = contrib_r;

endmodule

`default_nettype wire

### design/smcl_group.sv
// Registered first level of the match reduction over one group of cells.
// Uses smcl_pkg.
`default_nettype none

module smcl_group (
  input  wire              clk,
  input  wire              eq      [smcl_pkg::GROUP_SIZE],
  input  smcl_pkg::tally_t contrib [smcl_pkg::GROUP_SIZE],
  output logic             found,
  output smcl_pkg::tally_t count
);
  import smcl_pkg::*;

  logic   found_r;
  tally_t count_r;
  logic   found_nxt;
  tally_t count_nxt;

  // At most one cell matches, so an OR merges the group's answer.
  always_comb begin
    found_nxt = 1'b0;
    count_nxt = '0;
    for (int j = 0; j < GROUP_SIZE; j++) begin
      found_nxt = found_nxt | eq[j];
      count_nxt = count_nxt | contrib[j];
    end
  end

  always_ff @(posedge clk) begin
    found_r <= found_nxt;
    count_r <= count_nxt;
  end

  assign found = found_r;
  assign count = count_r;

endmodule

`default_nettype wire

### design/sorted_multiset_count_lookup_top.sv
// Sorted multiset count lookup: a chain of cells keeps a sorted key table.
// The result strobe follows the input transfer through the compare, group
// reduction and commit phases; a new item is taken only once busy is low.
// Reset (rst_n low, synchronous) clears the sequencer, the output strobe and
// the entry count; table contents are not cleared and need no clearing pass.
// The receiver cannot stall: each result is shown for one cycle only.
`default_nettype none

module sorted_multiset_count_lookup_top (
  input  wire            clk,
  input  wire            rst_n,
  input  wire            start,
  output logic           busy,
  input  smcl_pkg::in_t  in_data,
  output logic           out_strobe,
  output smcl_pkg::out_t out_data
);
  import smcl_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_CMP  = 4'b0010,
    ST_RED  = 4'b0100,
    ST_FIN  = 4'b1000
  } state_t;

  state_t              state_r, state_nxt;
  logic [USED_W-1:0]   used_r;
  logic                out_strobe_r;
  out_t                out_data_r;
  key_t                item_key_r;
  logic                item_func_r;
  ctrl_t               ctrl;
  logic                full;
  logic                found;
  tally_t              found_count;
  logic                is_insert;
  out_t                result;
  logic [COUNT_BITS+OUT_COUNT_W-1:0] count_ext;

  key_t   key_w     [CAPACITY];
  tally_t tally_w   [CAPACITY];
  logic   lt_w      [CAPACITY];
  logic   eq_w      [PAD_CELLS];
  tally_t contrib_w [PAD_CELLS];
  logic   grp_found [NUM_GROUPS];
  tally_t grp_count [NUM_GROUPS];

  // Sequencer: compare, reduce, then commit and report.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (start) state_nxt = ST_CMP;
      ST_CMP:  state_nxt = ST_RED;
      ST_RED:  state_nxt = ST_FIN;
      ST_FIN:  state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign busy      = (state_r != ST_IDLE);
  assign full      = (used_r == USED_W'(CAPACITY));
  assign is_insert = (item_func_r == FUNC_INSERT);

  // Second reduction level over the group registers.
  always_comb begin
    found       = 1'b0;
    found_count = '0;
    for (int g = 0; g < NUM_GROUPS; g++) begin
      found       = found | grp_found[g];
      found_count = found_count | grp_count[g];
    end
  end

  // Control broadcast to the cells.
  always_comb begin
    ctrl.cmp_en   = (state_r == ST_CMP);
    ctrl.shift_en = (state_r == ST_FIN) && is_insert && !found && !full;
    ctrl.inc_en   = (state_r == ST_FIN) && is_insert;
    ctrl.query    = (item_func_r == FUNC_QUERY);
    ctrl.key      = item_key_r;
  end

  // Result of the item being committed.
  always_comb begin
    count_ext = '0;
    if (found) begin
      count_ext = (COUNT_BITS + OUT_COUNT_W)'(found_count);
    end else if (is_insert && !full) begin
      count_ext = (COUNT_BITS + OUT_COUNT_W)'(1);
    end
    result.count   = count_ext[OUT_COUNT_W-1:0];
    result.dropped = is_insert && !found && full;
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      used_r       <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_strobe_r <= (state_r == ST_FIN);
      if (ctrl.shift_en) begin
        used_r <= used_r + USED_W'(1);
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if ((state_r == ST_IDLE) && start) begin
      item_func_r <= in_data.func;
      item_key_r  <= key_t'(in_data.value) ^ SIGN_FLIP;
    end
    if (state_r == ST_FIN) begin
      out_data_r <= result;
    end
  end

  assign out_strobe = out_strobe_r;
  assign out_data   = out_data_r;

  // Chain of cells; each one takes key and tally from its lower neighbor.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    key_t   prev_key;
    tally_t prev_tally;
    logic   prev_lt;
    logic   cell_valid;

    if (i == 0) begin : g_first
      assign prev_key   = '0;
      assign prev_tally = '0;
      assign prev_lt    = 1'b1;
    end else begin : g_rest
      assign prev_key   = key_w[i-1];
      assign prev_tally = tally_w[i-1];
      assign prev_lt    = lt_w[i-1];
    end

    assign cell_valid = (USED_W'(i) < used_r);

    smcl_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .valid      (cell_valid),
      .prev_key   (prev_key),
      .prev_tally (prev_tally),
      .prev_lt    (prev_lt),
      .key        (key_w[i]),
      .tally      (tally_w[i]),
      .lt         (lt_w[i]),
      .eq         (eq_w[i]),
      .contrib    (contrib_w[i])
    );
  end

  // Unused slots of the last group never match.
  for (genvar i = CAPACITY; i < PAD_CELLS; i++) begin : g_pad
    assign eq_w[i]      = 1'b0;
    assign contrib_w[i] = '0;
  end

  // First reduction level, one register stage per group.
  for (genvar g = 0; g < NUM_GROUPS; g++) begin : g_grp
    logic   grp_eq      [GROUP_SIZE];
    tally_t grp_contrib [GROUP_SIZE];

    for (genvar j = 0; j < GROUP_SIZE; j++) begin : g_sel
      assign grp_eq[j]      = eq_w[g*GROUP_SIZE + j];
      assign grp_contrib[j] = contrib_w[g*GROUP_SIZE + j];
    end

    smcl_group u_group (
      .clk     (clk),
      .eq      (grp_eq),
      .contrib (grp_contrib),
      .found   (grp_found[g]),
      .count   (grp_count[g])
    );
  end

endmodule

`default_nettype wire

### design/smcl_checker.sv
// Port-level checker for the sorted multiset count lookup, bound to the top.
// Uses smcl_pkg and the assertion macro header.
`default_nettype none
`include "sorted_multiset_count_lookup_top_assert.svh"

module smcl_checker (
  input wire            clk,
  input wire            rst_n,
  input wire            start,
  input wire            busy,
  input wire            out_strobe,
  input smcl_pkg::out_t out_data
);
  import smcl_pkg::*;

  logic in_xfer;
  logic drop_seen;

  assign in_xfer   = start && !busy;
  assign drop_seen = out_strobe && out_data.dropped;

  // An accepted transfer makes the block busy until its result.
  `SMCL_ASSERT_NXT(a_busy_after_xfer, clk, rst_n, in_xfer, busy, "busy did not rise")
  // Every transfer yields its result after the compare, reduce and commit states.
  `SMCL_ASSERT_IMP(a_result_latency, clk, rst_n, in_xfer, 1'b1 ##4 out_strobe, "late result")
  // Results are never back to back.
  `SMCL_ASSERT_NXT(a_strobe_single, clk, rst_n, out_strobe, !out_strobe, "double strobe")
  // A result appears only once the block is free again.
  `SMCL_ASSERT_IMP(a_strobe_idle, clk, rst_n, out_strobe, !busy, "strobe while busy")
  // A dropped insert reports a zero count.
  `SMCL_ASSERT_IMP(a_drop_zero, clk, rst_n, drop_seen, out_data.count == '0, "drop count")

endmodule

bind sorted_multiset_count_lookup_top smcl_checker u_smcl_checker (.*);

`default_nettype wire

### bench/sorted_multiset_count_lookup_top_test.sv
// Self-checking bench for the sorted multiset count lookup: directed rows, then random
// insert and query traffic that fills the table past capacity. Depends on smcl_pkg and
// sorted_multiset_count_lookup_top.
module sorted_multiset_count_lookup_top_test;
  import smcl_pkg::*;

  localparam int RANDOM_ITEMS = 1628;
  localparam int DRAIN_LIMIT = 200;
  localparam bit CHECK_TYPED = 1'b1;
  localparam bit CHECK_PREDICTED = 1'b0;
  localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] VAL_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] VAL_NEG_ONE = 32'shFFFF_FFFF;
  localparam tally_t TALLY_MAX = {COUNT_BITS{1'b1}};

  typedef struct {
    in_t  item;
    bit   typed;
    out_t want;
  } card_row_t;

  typedef struct {
    in_t  item;
    out_t want;
  } pending_tally_t;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  in_t  in_data;
  logic out_strobe;
  out_t out_data;

  // Shadow copy of the sorted table.
  logic signed [31:0] tbl_keys [CAPACITY];
  tally_t             tbl_tallies [CAPACITY];
  int                 tbl_used;

  card_row_t      card_rows [$];
  pending_tally_t pending_tallies [$];
  int             mismatch_count;

  sorted_multiset_count_lookup_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_data    (in_data),
    .out_strobe (out_strobe),
    .out_data   (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH: %s", msg);
    mismatch_count++;
  endtask

  // Applies one item to the shadow table and returns the tally it reports.
  function automatic out_t tally_table_apply(input in_t item);
    int   pos;
    int   i;
    bit   hit;
    out_t res;
    res = '0;
    pos = 0;
    while (pos < tbl_used && tbl_keys[pos] < item.value) pos++;
    hit = (pos < tbl_used) && (tbl_keys[pos] == item.value);
    if (item.func == FUNC_QUERY) begin
      if (hit) res.count = tbl_tallies[pos];
    end else if (hit) begin
      if (tbl_tallies[pos] != TALLY_MAX) tbl_tallies[pos] = tbl_tallies[pos] + 1'b1;
      res.count = tbl_tallies[pos];
    end else if (tbl_used >= CAPACITY) begin
      res.dropped = 1'b1;
    end else begin
      for (i = tbl_used; i > pos; i--) begin
        tbl_keys[i] = tbl_keys[i-1];
        tbl_tallies[i] = tbl_tallies[i-1];
      end
      tbl_keys[pos] = item.value;
      tbl_tallies[pos] = tally_t'(1);
      tbl_used++;
      res.count = OUT_COUNT_W'(1);
    end
    return res;
  endfunction

  task automatic add_row(input logic f, input logic signed [31:0] v, input bit typed,
                         input int unsigned cnt);
    card_row_t row;
    row.item.func = f;
    row.item.value = v;
    row.typed = typed;
    row.want.count = OUT_COUNT_W'(cnt);
    row.want.dropped = 1'b0;
    card_rows = {card_rows, row};
  endtask

  // A value that is most likely absent: random, an extreme, or next to a stored key.
  function automatic logic signed [31:0] fresh_value();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) begin
      case ($urandom_range(0, 3))
        0: return VAL_MIN;
        1: return VAL_MAX;
        2: return 32'sd0;
        default: return VAL_NEG_ONE;
      endcase
    end
    if (sel <= 2 && tbl_used > 0) begin
      if ($urandom_range(0, 1) == 1) return tbl_keys[$urandom_range(0, tbl_used - 1)] + 1;
      return tbl_keys[$urandom_range(0, tbl_used - 1)] - 1;
    end
    return $urandom;
  endfunction

  function automatic logic signed [31:0] stored_value();
    if (tbl_used == 0) return $urandom;
    return tbl_keys[$urandom_range(0, tbl_used - 1)];
  endfunction

  // Mostly new inserts so the table fills up, then overflows and drops.
  function automatic in_t pick_card();
    in_t item;
    int  r;
    r = $urandom_range(0, 99);
    if (r < 70) begin
      item.func = FUNC_INSERT;
      item.value = fresh_value();
    end else if (r < 80) begin
      item.func = FUNC_INSERT;
      item.value = stored_value();
    end else if (r < 92) begin
      item.func = FUNC_QUERY;
      item.value = stored_value();
    end else begin
      item.func = FUNC_QUERY;
      item.value = fresh_value();
    end
    return item;
  endfunction

  // Short gaps dominate; every third block of 100 items runs back to back.
  function automatic int pick_gap(input int idx);
    int r;
    if ((idx / 100) % 3 == 2) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 20);
  endfunction

  // Drives one item and waits for its transfer; start stays high into the next item
  // when there is no gap.
  task automatic send_card(input int idx, input in_t item, input bit typed, input out_t want);
    int             gap;
    pending_tally_t entry;
    gap = pick_gap(idx);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_data <= item;
    @(posedge clk);
    while (busy) @(posedge clk);
    entry.item = item;
    entry.want = tally_table_apply(item);
    if (typed) entry.want = want;
    pending_tallies = {pending_tallies, entry};
  endtask

  // Each strobed result is checked against the oldest pending tally.
  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      if (pending_tallies.size() == 0) begin
        report_mismatch($sformatf("unexpected result count=%0d dropped=%0b",
                                  out_data.count, out_data.dropped));
      end else begin
        pending_tally_t head;
        head = pending_tallies.pop_front();
        if (out_data.count !== head.want.count)
          report_mismatch($sformatf("func=%0b value=%0d count=%0d, want %0d",
                                    head.item.func, head.item.value,
                                    out_data.count, head.want.count));
        if (out_data.dropped !== head.want.dropped)
          report_mismatch($sformatf("func=%0b value=%0d dropped=%0b, want %0b",
                                    head.item.func, head.item.value,
                                    out_data.dropped, head.want.dropped));
      end
    end
  end

  // Stimulus: reset, directed rows, random traffic, then drain.
  initial begin
    in_t  item;
    out_t none;
    int   idx;
    int   drain;
    rst_n = 1'b0;
    start = 1'b0;
    in_data = '0;
    none = '0;
    tbl_used = 0;
    mismatch_count = 0;

    // Empty table, extremes, neighbors and repeated inserts.
    add_row(FUNC_QUERY,  32'sd0,      CHECK_TYPED, 0);
    add_row(FUNC_QUERY,  VAL_MIN,     CHECK_TYPED, 0);
    add_row(FUNC_QUERY,  VAL_MAX,     CHECK_TYPED, 0);
    add_row(FUNC_INSERT, VAL_MIN,     CHECK_TYPED, 1);
    add_row(FUNC_INSERT, VAL_MAX,     CHECK_TYPED, 1);
    add_row(FUNC_INSERT, 32'sd0,      CHECK_TYPED, 1);
    add_row(FUNC_INSERT, VAL_NEG_ONE, CHECK_TYPED, 1);
    add_row(FUNC_INSERT, VAL_MIN,     CHECK_TYPED, 2);
    add_row(FUNC_INSERT, VAL_MAX,     CHECK_TYPED, 2);
    add_row(FUNC_QUERY,  VAL_MIN,     CHECK_TYPED, 2);
    add_row(FUNC_QUERY,  VAL_MAX,     CHECK_TYPED, 2);
    add_row(FUNC_QUERY,  32'sd1,      CHECK_TYPED, 0);
    add_row(FUNC_INSERT, 32'sd1,      CHECK_PREDICTED, 0);
    add_row(FUNC_QUERY,  VAL_NEG_ONE, CHECK_PREDICTED, 0);
    add_row(FUNC_INSERT, 32'sd0,      CHECK_PREDICTED, 0);
    add_row(FUNC_QUERY,  32'sd0,      CHECK_PREDICTED, 0);
    add_row(FUNC_INSERT, VAL_MIN + 1, CHECK_PREDICTED, 0);
    add_row(FUNC_INSERT, VAL_MAX - 1, CHECK_PREDICTED, 0);
    add_row(FUNC_QUERY,  VAL_MIN + 1, CHECK_PREDICTED, 0);
    add_row(FUNC_QUERY,  32'sh5555_5555, CHECK_PREDICTED, 0);
    add_row(FUNC_INSERT, 32'shAAAA_AAAA, CHECK_PREDICTED, 0);
    add_row(FUNC_INSERT, 32'sh5555_5555, CHECK_PREDICTED, 0);

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    idx = 0;
    foreach (card_rows[i]) begin
      send_card(idx, card_rows[i].item, card_rows[i].typed, card_rows[i].want);
      idx++;
    end
    repeat (RANDOM_ITEMS) begin
      item = pick_card();
      send_card(idx, item, CHECK_PREDICTED, none);
      idx++;
    end
    start <= 1'b0;

    drain = 0;
    while (pending_tallies.size() != 0 && drain < DRAIN_LIMIT) begin
      @(posedge clk);
      drain++;
    end
    repeat (8) @(posedge clk);
    if (pending_tallies.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", pending_tallies.size()));
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Watchdog far beyond the slowest legal run.
  initial begin
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

### files.f
+incdir+design
design/smcl_pkg.sv
design/smcl_cell.sv
design/smcl_group.sv
design/sorted_multiset_count_lookup_top.sv
design/smcl_checker.sv
bench/sorted_multiset_count_lookup_top_test.sv
